@@ design/modinv_pkg.sv @@
// modinv_pkg: command and status bundles shared by the modular inverse
// controller, datapath and top level; no dependencies
package modinv_pkg;

  typedef struct packed {
    logic load;          // take a new request into the operand registers
    logic start_round;   // set up one euclid round division
    logic step;          // one quotient bit of the running division
    logic commit_pre;    // reduction of value modulo modulus is complete
    logic commit_round;  // euclid round complete, shift remainders and coefficients
    logic finish;        // write the result register
  } modinv_cmd_t;

  typedef struct packed {
    logic mod_small;     // modulus below two
    logic r1_zero;       // remainder sequence has reached zero
    logic last_bit;      // division is on its final quotient bit
    logic out_free;      // result register can take a new result
  } modinv_status_t;

endpackage

@@ design/modinv_datapath.sv @@
// modinv_datapath: remainder and coefficient registers, bit-serial divider
// with shift-add quotient product, and the result register; uses modinv_pkg
module modinv_datapath #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  modinv_pkg::modinv_cmd_t    cmd,
  output modinv_pkg::modinv_status_t status,
  input  logic [DATA_WIDTH-1:0]      value,
  input  logic [DATA_WIDTH-1:0]      modulus,
  output logic [DATA_WIDTH-1:0]      inverse,
  output logic                       exists,
  output logic                       out_valid,
  input  logic                       out_ready
);
  import modinv_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [W-1:0]     modr;
  logic [W-1:0]     r0;
  logic [W-1:0]     r1;
  logic [W:0]       t0;      // two's complement, magnitude below modulus
  logic [W:0]       t1;
  logic [W-1:0]     num;     // dividend, shifted out msb first
  logic [W-1:0]     rem;
  logic [W:0]       acc;     // running quotient times t1, wraps
  logic [CNT_W-1:0] cnt;
  logic             pre_mode;

  logic [W-1:0] divisor;
  logic [W:0]   rem_sh;
  logic         ge;
  logic [W:0]   rem_diff;
  logic [W-1:0] rem_next;
  logic [W:0]   acc_next;
  logic [W:0]   t0_fixed;
  logic         ok;

  assign divisor  = pre_mode ? r0 : r1;
  assign rem_sh   = {rem, num[W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign rem_next = ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
  assign acc_next = {acc[W-1:0], 1'b0} + (ge ? t1 : '0);

  // negative coefficient is brought into 0 to modulus-1
  assign t0_fixed = t0[W] ? (t0 + {1'b0, modr}) : t0;
  assign ok       = (modr >= W'(2)) && (r0 == W'(1));

  assign status.mod_small = modr < W'(2);
  assign status.r1_zero   = r1 == '0;
  assign status.last_bit  = cnt == CNT_W'(W - 1);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      modr     <= modulus;
      r0       <= modulus;
      num      <= value;
      rem      <= '0;
      acc      <= '0;
      cnt      <= '0;
      t0       <= '0;
      t1       <= (W+1)'(1);
      pre_mode <= 1'b1;
    end else if (cmd.start_round) begin
      num      <= r0;
      rem      <= '0;
      acc      <= '0;
      cnt      <= '0;
      pre_mode <= 1'b0;
    end else if (cmd.step) begin
      num <= {num[W-2:0], 1'b0};
      rem <= rem_next;
      acc <= acc_next;
      cnt <= cnt + CNT_W'(1);
      if (cmd.commit_pre) begin
        r1 <= rem_next;
      end
      if (cmd.commit_round) begin
        r0 <= r1;
        r1 <= rem_next;
        t0 <= t1;
        t1 <= t0 - acc_next;
      end
    end
    if (cmd.finish) begin
      exists  <= ok;
      inverse <= ok ? t0_fixed[W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/modinv_ctrl.sv @@
// modinv_ctrl: sequencer for reduction, euclid rounds and result write
// drives the datapath through modinv_pkg command and status bundles
module modinv_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  modinv_pkg::modinv_status_t status,
  output modinv_pkg::modinv_cmd_t    cmd
);
  import modinv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.step = 1'b1;
        if (status.last_bit) begin
          cmd.commit_pre = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.mod_small || status.r1_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.start_round = 1'b1;
          state_next      = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_bit) begin
          cmd.commit_round = 1'b1;
          state_next       = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/modular_inverse_core.sv @@
// modular_inverse_core: inverse of value modulo modulus by extended euclid
// the reduction of value modulo modulus and each euclid round are bit-serial
// divisions, with up to about 45 euclid rounds for 31-bit operands;
// one request at a time
// a new request is taken while the previous result still waits on the output
// rst is synchronous; it clears the sequencer and the result valid flag only
module modular_inverse_core #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // value, modulus from the lsb up, zero padded
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // inverse, exists from the lsb up, zero padded
  output logic [((DATA_WIDTH+8)/8)*8-1:0]   m_tdata
);
  import modinv_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int OUT_DW = ((DATA_WIDTH + 8) / 8) * 8;

  modinv_cmd_t    cmd;
  modinv_status_t status;
  logic [W-1:0]   inverse;
  logic           exists;

  modinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  modinv_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (s_tdata[W-1:0]),
    .modulus   (s_tdata[2*W-1:W]),
    .inverse   (inverse),
    .exists    (exists),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = OUT_DW'({exists, inverse});

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for modular_inverse_core, inverse of value mod modulus
// needs the design files (modinv_pkg first); expected results come from a local
// extended euclid predictor, plus hand-typed answers for the obvious table rows
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW  = 31;
  localparam int S_W = ((2*DW+7)/8)*8;
  localparam int M_W = ((DW+8)/8)*8;
  localparam logic [DW-1:0] TOP = {DW{1'b1}};  // 2^31-1, a prime
  localparam int RANDOM_REQUESTS = 500;
  localparam int LONG_HOLD = 6000;
  localparam int DRAIN_CYCLES = 1600;

  typedef struct packed {
    logic [DW-1:0] inverse;
    logic          exists;
  } inv_result_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic [DW-1:0] modulus;
    logic          known;
    inv_result_t   answer;
  } request_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata = '0;  // value, modulus from the lsb up, zero padded
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;       // inverse, exists from the lsb up, zero padded

  inv_result_t  pending_inverses[$];
  request_row_t directed_rows[$];
  int           error_count = 0;
  bit           no_idle = 1'b0;
  bit           long_hold_request = 1'b0;

  modular_inverse_core #(.DATA_WIDTH(DW)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // extended euclid on signed 64-bit; coefficients stay within (-m, m)
  function automatic inv_result_t expected_inverse(logic [DW-1:0] value,
                                                   logic [DW-1:0] modulus);
    longint rem_a, rem_b, coef_a, coef_b, quot, tmp;
    inv_result_t res;
    res.inverse = '0;
    res.exists = 1'b0;
    if (modulus < 2) return res;
    rem_a = longint'(modulus);
    rem_b = longint'(value) % longint'(modulus);
    coef_a = 0;
    coef_b = 1;
    while (rem_b != 0) begin
      quot = rem_a / rem_b;
      tmp = rem_a - quot * rem_b;
      rem_a = rem_b;
      rem_b = tmp;
      tmp = coef_a - quot * coef_b;
      coef_a = coef_b;
      coef_b = tmp;
    end
    if (rem_a != 1) return res;
    if (coef_a < 0) coef_a += longint'(modulus);
    res.inverse = coef_a[DW-1:0];
    res.exists = 1'b1;
    return res;
  endfunction

  function automatic longint fibonacci(int k);
    longint a, b, tmp;
    a = 0;
    b = 1;
    for (int i = 0; i < k; i++) begin
      tmp = a + b;
      a = b;
      b = tmp;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic add_row(logic [DW-1:0] value, logic [DW-1:0] modulus, logic known,
                         logic [DW-1:0] inverse, logic exists);
    request_row_t row;
    row.value = value;
    row.modulus = modulus;
    row.known = known;
    row.answer.inverse = inverse;
    row.answer.exists = exists;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(logic [DW-1:0] value, logic [DW-1:0] modulus,
                              logic known, inv_result_t answer);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_W-2*DW){1'b0}}, modulus, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_inverses.push_back(known ? answer : expected_inverse(value, modulus));
  endtask

  task automatic draw_request(output logic [DW-1:0] value, output logic [DW-1:0] modulus);
    int unsigned g, a, b;
    int k;
    value = DW'($urandom);
    modulus = DW'($urandom_range(32'h7fffffff, 2));
    case ($urandom_range(0, 9))
      4: modulus = DW'($urandom_range(300, 2));
      5: value = DW'($urandom % modulus);
      6: begin
        // shared factor, so never invertible
        g = $urandom_range(1000, 2);
        a = $urandom_range(32'h7fffffff / g, 0);
        b = $urandom_range(32'h7fffffff / g, 1);
        value = DW'(g * a);
        modulus = DW'(g * b);
      end
      7: modulus = TOP;
      8: begin
        // consecutive fibonacci numbers give the longest runs of rounds
        k = int'($urandom_range(45, 20));
        value = DW'(fibonacci(k));
        modulus = DW'(fibonacci(k + 1));
      end
      9: begin
        case ($urandom_range(0, 4))
          0: value = '0;
          1: modulus = '0;
          2: modulus = DW'(1);
          3: value = modulus;
          default: value = modulus + 1'b1;
        endcase
      end
      default: ;
    endcase
  endtask

  // result side: random stall before each result unless no_idle is set, one long hold on request
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_request) begin
        hold = LONG_HOLD;
        long_hold_request = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    inv_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", m_tdata, 0);
      end else begin
        want = pending_inverses.pop_front();
        if (m_tdata[DW-1:0] !== want.inverse)
          report_mismatch("inverse", m_tdata[DW-1:0], want.inverse);
        if (m_tdata[DW] !== want.exists)
          report_mismatch("exists", m_tdata[DW], want.exists);
      end
    end
  end

  initial begin
    logic [DW-1:0] value, modulus;
    inv_result_t unused;
    unused = '0;

    add_row('0, 7, 1, '0, 0);                          // zero value
    add_row('0, '0, 1, '0, 0);
    add_row('0, 1, 1, '0, 0);
    add_row(5, '0, 1, '0, 0);                          // modulus below two
    add_row(5, 1, 1, '0, 0);
    add_row(TOP, '0, 1, '0, 0);
    add_row(1, 2, 1, 1, 1);
    add_row(3, 7, 1, 5, 1);
    add_row(10, 7, 1, 5, 1);                           // value reduced first
    add_row(6, 9, 1, '0, 0);                           // shared factor
    add_row(TOP, TOP, 1, '0, 0);                       // reduces to zero
    add_row(TOP - 1'b1, TOP, 1, TOP - 1'b1, 1);
    add_row(1, TOP, 1, 1, 1);
    add_row(2, TOP, 1, DW'(32'h4000_0000), 1);
    add_row(TOP, 2, 1, 1, 1);
    add_row(TOP, TOP - 1'b1, 1, 1, 1);
    add_row(DW'(1134903170), DW'(1836311903), 0, '0, 0);  // longest euclid run
    add_row(DW'(1836311903), DW'(1134903170), 0, '0, 0);
    add_row(DW'(32'h5555_5555), DW'(32'h2aaa_aaaa), 0, '0, 0);
    add_row(DW'(32'h2aaa_aaab), TOP - 1'b1, 0, '0, 0);
    add_row(DW'(123456789), DW'(1000000007), 0, '0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].modulus,
                   directed_rows[i].known, directed_rows[i].answer);

    // let the table drain before the random requests
    s_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 150) long_hold_request = 1'b1;
      if (n == 300) begin
        s_tvalid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge clk);
      end
      no_idle = (n >= 350 && n < 400);
      draw_request(value, modulus);
      send_request(value, modulus, 1'b0, unused);
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_inverses.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
design/modinv_pkg.sv
design/modinv_datapath.sv
design/modinv_ctrl.sv
design/modular_inverse_core.sv
bench/tb.sv
